>>> sv/pip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants and types for the point-in-polygon crossing-number test.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int COORD_BITS   = 16;
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_W       = COORD_BITS + 1;
   localparam int PROD_W       = 2 * DIFF_W;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic      kind;
      logic      restart;
      coord_type x_coord;
      coord_type y_coord;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic truncated;
   } rsp_type;

   // query point travelling down the chain with its running crossing parity
   typedef struct packed {
      logic      valid;
      coord_type x;
      coord_type y;
      logic      parity;
   } point_type;

   // vertex write broadcast to every cell
   typedef struct packed {
      logic             en;
      logic             clear;
      logic [CNT_W-1:0] idx;
      coord_type        x;
      coord_type        y;
      coord_type        first_x;
      coord_type        first_y;
   } vwr_type;

endpackage : pip_pkg
`default_nettype wire

>>> sv/pip_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_cell
// One polygon edge: holds both end points, tests the passing query point
// against the edge and hands the point on with its updated parity.
// ----------------------------------------------------------------------------
module pip_cell (
   input  wire                            clock,
   input  wire                            reset,
   input  wire logic [pip_pkg::CNT_W-1:0] cell_index,
   input  wire logic                      adv,
   input  wire pip_pkg::vwr_type          wr,
   input  wire pip_pkg::point_type        pin,
   output pip_pkg::point_type             pout
);
   import pip_pkg::*;

   coord_type        ax_ff, ay_ff, bx_ff, by_ff;
   logic             active_ff;
   point_type        pt_ff, pt_in;
   logic [CNT_W-1:0] next_index;

   coord_type               lx, ly, hx, hy;
   logic                    lo_is_a, span_ok, crosses;
   logic signed [DIFF_W-1:0] d_py, d_bx, d_px, d_by;
   logic signed [PROD_W-1:0] lhs, rhs;

   assign next_index = cell_index + CNT_W'(1);

   // order the end points so that ly < hy for a non-horizontal edge
   assign lo_is_a = (ay_ff < by_ff);
   assign lx      = lo_is_a ? ax_ff : bx_ff;
   assign ly      = lo_is_a ? ay_ff : by_ff;
   assign hx      = lo_is_a ? bx_ff : ax_ff;
   assign hy      = lo_is_a ? by_ff : ay_ff;

   // half-open span; a horizontal edge never satisfies it
   assign span_ok = (ly <= pin.y) && (pin.y < hy);

   assign d_py = DIFF_W'(pin.y) - DIFF_W'(ly);
   assign d_bx = DIFF_W'(hx)    - DIFF_W'(lx);
   assign d_px = DIFF_W'(pin.x) - DIFF_W'(lx);
   assign d_by = DIFF_W'(hy)    - DIFF_W'(ly);

   assign lhs = PROD_W'(d_py) * PROD_W'(d_bx);
   assign rhs = PROD_W'(d_px) * PROD_W'(d_by);

   assign crosses = active_ff && span_ok && (lhs <= rhs);

   always_comb begin
      pt_in        = pin;
      pt_in.parity = pin.parity ^ (pin.valid & crosses);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         pt_ff.valid <= 1'b0;
      end else begin
         if (adv) begin
            pt_ff <= pt_in;
         end
         if (wr.en && wr.clear) begin
            active_ff <= 1'b0;
         end
         if (wr.en && (wr.idx == cell_index)) begin
            active_ff <= 1'b1;
         end
      end
      // edge end points: own vertex, then the closing vertex until the next arrives
      if (wr.en && (wr.idx == cell_index)) begin
         ax_ff <= wr.x;
         ay_ff <= wr.y;
         bx_ff <= wr.first_x;
         by_ff <= wr.first_y;
      end else if (wr.en && (wr.idx == next_index)) begin
         bx_ff <= wr.x;
         by_ff <= wr.y;
      end
   end

   assign pout = pt_ff;

endmodule : pip_cell
`default_nettype wire

>>> sv/point_in_polygon_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd point-in-polygon test over a chain of edge cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries vertex items (kind 0) and query items (kind 1); rsp_*
//   carries one result per query item, none for vertex items.
//   A vertex transfer with restart set starts a new polygon. Vertices beyond
//   MAX_VERTICES are dropped and reported through truncated.
//   Each cell holds one edge; a query point walks the chain of MAX_VERTICES
//   cells, one cell per cycle while the chain is not held, toggling its
//   parity at every crossing edge. A query passes through the MAX_VERTICES
//   cell registers on its way to rsp_valid. Queries enter one per cycle
//   while the chain is not held, so up to MAX_VERTICES are in flight.
//   A vertex item is held off (req_stall) until every query in flight has been delivered, since it changes the edges.
//   When rsp_stall is high with a result waiting, the whole chain holds and
//   req_stall rises; nothing is lost or reordered.
//   Reset empties the polygon, clears the overflow flag and the chain.
// ----------------------------------------------------------------------------
module point_in_polygon_test (
   input  wire                      clock,
   input  wire                      reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire pip_pkg::req_type    req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output pip_pkg::rsp_type         rsp_data
);
   import pip_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] inflight_ff, inflight_in;
   logic             overflow_ff, overflow_in;
   coord_type        first_x_ff, first_y_ff;

   logic             adv;
   logic             req_xfer, rsp_xfer, vtx_xfer, qry_xfer;
   logic [CNT_W-1:0] base_count;
   vwr_type          wr;
   point_type        chain [0:MAX_VERTICES];

   assign adv      = !(rsp_valid && rsp_stall);
   assign req_stall = !adv || ((req_data.kind == KIND_VERTEX) && (inflight_ff != '0));
   assign req_xfer = req_valid && !req_stall;
   assign vtx_xfer = req_xfer && (req_data.kind == KIND_VERTEX);
   assign qry_xfer = req_xfer && (req_data.kind == KIND_QUERY);
   assign rsp_xfer = rsp_valid && !rsp_stall;

   assign base_count = req_data.restart ? '0 : count_ff;

   always_comb begin
      wr         = '0;
      wr.clear   = req_data.restart;
      wr.idx     = base_count;
      wr.x       = req_data.x_coord;
      wr.y       = req_data.y_coord;
      wr.first_x = (base_count == '0) ? req_data.x_coord : first_x_ff;
      wr.first_y = (base_count == '0) ? req_data.y_coord : first_y_ff;
      wr.en      = vtx_xfer && (base_count < CNT_W'(MAX_VERTICES));
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (vtx_xfer) begin
         overflow_in = req_data.restart ? 1'b0 : overflow_ff;
         if (base_count < CNT_W'(MAX_VERTICES)) begin
            count_in = base_count + CNT_W'(1);
         end else begin
            count_in    = base_count;
            overflow_in = 1'b1;
         end
      end
      inflight_in = inflight_ff + CNT_W'(qry_xfer) - CNT_W'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         inflight_ff <= '0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         inflight_ff <= inflight_in;
      end
      if (wr.en && (base_count == '0)) begin
         first_x_ff <= req_data.x_coord;
         first_y_ff <= req_data.y_coord;
      end
   end

   always_comb begin
      chain[0].valid  = qry_xfer;
      chain[0].x      = req_data.x_coord;
      chain[0].y      = req_data.y_coord;
      chain[0].parity = 1'b0;
   end

   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
      pip_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CNT_W'(k)),
         .adv        (adv),
         .wr         (wr),
         .pin        (chain[k]),
         .pout       (chain[k+1])
      );
   end

   assign rsp_valid           = chain[MAX_VERTICES].valid;
   assign rsp_data.inside_res = chain[MAX_VERTICES].parity;
   assign rsp_data.truncated  = overflow_ff;

   a_rsp_has_query : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (inflight_ff != '0))
      else $error("result without a query in flight");

   a_vertex_when_idle : assert property (@(posedge clock) disable iff (reset)
      vtx_xfer |-> (inflight_ff == '0))
      else $error("vertex transfer while queries in flight");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond capacity");

   a_overflow_full : assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (count_ff == CNT_W'(MAX_VERTICES)))
      else $error("overflow flagged with free capacity");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data.inside_res)))
      else $error("result changed while held");

endmodule : point_in_polygon_test
`default_nettype wire

>>> tb/tb_point_in_polygon_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test
// Self-checking bench for the even-odd point-in-polygon block. Vertex and
// query transfers are driven under random idling on both channels. A shadow
// polygon predicts each query's inside/truncated verdict, and every result
// transfer is checked in order against it.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test;
   import pip_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = MAX_VERTICES + 16;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow polygon
   coord_type poly_x [MAX_VERTICES];
   coord_type poly_y [MAX_VERTICES];
   int        poly_count    = 0;
   logic      poly_overflow = 1'b0;
   rsp_type   pending_verdicts [$];

   int send_idle_pct    = 0;
   int recv_idle_pct    = 0;
   int hold_token       = 0;
   int hold_seen        = 0;
   int hold_left        = 0;
   int idle_cycles      = 0;
   int error_count      = 0;
   int vertices_sent    = 0;
   int queries_sent     = 0;
   int verdicts_checked = 0;
   int overflow_runs    = 0;

   point_in_polygon_test uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic logic edge_crosses_ray(input coord_type x1, input coord_type y1,
                                             input coord_type x2, input coord_type y2,
                                             input coord_type px, input coord_type py);
      coord_type                ax, ay, bx, by;
      logic signed [DIFF_W-1:0] dy_pt, dx_edge, dx_pt, dy_edge;
      logic signed [PROD_W-1:0] lhs, rhs;
      if (y1 == y2) return 1'b0;
      if (y1 < y2) begin
         ax = x1; ay = y1; bx = x2; by = y2;
      end else begin
         ax = x2; ay = y2; bx = x1; by = y1;
      end
      // half-open span: bottom end counts, top end does not
      if (!(ay <= py && py < by)) return 1'b0;
      dy_pt   = DIFF_W'(py) - DIFF_W'(ay);
      dx_edge = DIFF_W'(bx) - DIFF_W'(ax);
      dx_pt   = DIFF_W'(px) - DIFF_W'(ax);
      dy_edge = DIFF_W'(by) - DIFF_W'(ay);
      lhs     = PROD_W'(dy_pt) * PROD_W'(dx_edge);
      rhs     = PROD_W'(dx_pt) * PROD_W'(dy_edge);
      return (lhs <= rhs);
   endfunction

   function automatic logic point_parity(input coord_type px, input coord_type py);
      logic parity;
      int   j;
      parity = 1'b0;
      for (int i = 0; i < poly_count; i++) begin
         // closing edge wraps to vertex 0
         j = (i + 1 < poly_count) ? i + 1 : 0;
         parity ^= edge_crosses_ray(poly_x[i], poly_y[i], poly_x[j], poly_y[j], px, py);
      end
      return parity;
   endfunction

   function automatic void track_polygon_item(input req_type item);
      rsp_type verdict;
      if (item.kind == KIND_VERTEX) begin
         vertices_sent++;
         if (item.restart) begin
            poly_count    = 0;
            poly_overflow = 1'b0;
         end
         if (poly_count < MAX_VERTICES) begin
            poly_x[poly_count] = item.x_coord;
            poly_y[poly_count] = item.y_coord;
            poly_count++;
         end else begin
            poly_overflow = 1'b1;
         end
      end else begin
         queries_sent++;
         verdict.inside_res = point_parity(item.x_coord, item.y_coord);
         verdict.truncated  = poly_overflow;
         pending_verdicts.push_back(verdict);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------
   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_polygon_item(item);
   endtask

   task automatic send_vertex(input logic restart, input coord_type x, input coord_type y);
      req_type item;
      item.kind    = KIND_VERTEX;
      item.restart = restart;
      item.x_coord = x;
      item.y_coord = y;
      send_item(item);
   endtask

   task automatic send_query(input coord_type x, input coord_type y, input logic restart);
      req_type item;
      item.kind    = KIND_QUERY;
      item.restart = restart;
      item.x_coord = x;
      item.y_coord = y;
      send_item(item);
   endtask

   // hold the sender until every verdict has arrived
   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   function automatic coord_type clamp_coord(input int v);
      if (v > 32767) return coord_type'(16'h7fff);
      if (v < -32768) return coord_type'(16'h8000);
      return coord_type'(v);
   endfunction

   function automatic coord_type random_coord(input int centre, input int span);
      if (span >= 32767) return coord_type'($urandom);
      return clamp_coord(centre + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic coord_type extreme_coord();
      case ($urandom_range(0, 2))
         0: return coord_type'(16'h7fff);
         1: return coord_type'(16'h8000);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic int pick_span();
      case ($urandom_range(0, 3))
         0: return 3;
         1: return 60;
         2: return 1500;
         default: return 32767;
      endcase
   endfunction

   task automatic load_polygon(input int n, input int span);
      int cx, cy;
      cx = int'(coord_type'($urandom));
      cy = int'(coord_type'($urandom));
      for (int i = 0; i < n; i++)
         send_vertex(i == 0, random_coord(cx, span), random_coord(cy, span));
   endtask

   task automatic send_random_query();
      int        sel, k, lo_x, hi_x, lo_y, hi_y;
      coord_type qx, qy;
      sel = $urandom_range(0, 99);
      if (poly_count == 0 || sel >= 85) begin
         qx = coord_type'($urandom);
         qy = coord_type'($urandom);
      end else if (sel >= 75) begin
         qx = extreme_coord();
         qy = extreme_coord();
      end else if (sel >= 50) begin
         // land on a vertex's row to work the half-open rule
         k  = $urandom_range(0, poly_count - 1);
         qy = poly_y[k];
         qx = (sel >= 62) ? poly_x[k]
                          : clamp_coord(int'(poly_x[k]) + int'($urandom_range(0, 8)) - 4);
      end else begin
         lo_x = 32767; hi_x = -32768; lo_y = 32767; hi_y = -32768;
         for (int i = 0; i < poly_count; i++) begin
            if (int'(poly_x[i]) < lo_x) lo_x = int'(poly_x[i]);
            if (int'(poly_x[i]) > hi_x) hi_x = int'(poly_x[i]);
            if (int'(poly_y[i]) < lo_y) lo_y = int'(poly_y[i]);
            if (int'(poly_y[i]) > hi_y) hi_y = int'(poly_y[i]);
         end
         qx = clamp_coord(lo_x - 2 + int'($urandom_range(0, hi_x - lo_x + 4)));
         qy = clamp_coord(lo_y - 2 + int'($urandom_range(0, hi_y - lo_y + 4)));
      end
      send_query(qx, qy, $urandom_range(0, 1) == 1);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed_cases();
      // empty polygon, then restart on a query which must be ignored
      send_query(16'sd0, 16'sd0, 1'b0);
      send_query(16'sh7fff, 16'sh8000, 1'b1);
      // single vertex: only a horizontal self-edge
      send_vertex(1'b1, 16'sd5, 16'sd5);
      send_query(16'sd5, 16'sd5, 1'b0);
      send_query(16'sd10, 16'sd5, 1'b0);
      // full-range square
      send_vertex(1'b1, 16'sh8000, 16'sh8000);
      send_vertex(1'b0, 16'sh7fff, 16'sh8000);
      send_vertex(1'b0, 16'sh7fff, 16'sh7fff);
      send_vertex(1'b0, 16'sh8000, 16'sh7fff);
      send_query(16'sd0, 16'sd0, 1'b0);
      send_query(16'sh8000, 16'sh8000, 1'b0);
      send_query(16'sh7fff, 16'sh7fff, 1'b0);
      send_query(16'sh8000, 16'sd0, 1'b0);
      send_query(16'sh7fff, 16'sd0, 1'b0);
      send_query(16'sd0, 16'sh7fff, 1'b0);
      send_query(16'sd0, 16'sh8000, 1'b0);
      // triangle with a horizontal base
      send_vertex(1'b1, 16'sd0, 16'sd0);
      send_vertex(1'b0, 16'sd100, 16'sd0);
      send_vertex(1'b0, 16'sd50, 16'sd100);
      send_query(16'sd50, 16'sd0, 1'b0);
      send_query(16'sd50, 16'sd50, 1'b0);
      send_query(16'sd0, 16'sd0, 1'b0);
      send_query(16'sd50, 16'sd100, 1'b0);
      send_query(-16'sd1, 16'sd50, 1'b0);
   endtask

   task automatic test_store_overflow();
      repeat (3) begin
         load_polygon(MAX_VERTICES, pick_span());
         repeat (4) send_random_query();
         // drop the surplus, with and without restart mixed in later
         repeat ($urandom_range(1, 5))
            send_vertex(1'b0, coord_type'($urandom), coord_type'($urandom));
         repeat (4) send_random_query();
         load_polygon($urandom_range(3, 6), pick_span());
         repeat (3) send_random_query();
         overflow_runs++;
      end
   endtask

   task automatic test_random_polygons(input int items_wanted);
      int first, r, s, n, cy;
      req_type noise;
      first = vertices_sent + queries_sent;
      while (vertices_sent + queries_sent - first < items_wanted) begin
         r = $urandom_range(0, 99);
         if (r < 72) begin
            s = $urandom_range(0, 99);
            if (s < 78) n = $urandom_range(3, 10);
            else if (s < 93) n = $urandom_range(11, 40);
            else n = $urandom_range(55, MAX_VERTICES + 6);
            if (n > MAX_VERTICES) overflow_runs++;
            load_polygon(n, pick_span());
            repeat ($urandom_range(4, 24)) send_random_query();
         end else if (r < 84) begin
            // extend the current polygon
            repeat ($urandom_range(1, 3))
               send_vertex(1'b0, coord_type'($urandom), coord_type'($urandom));
            repeat ($urandom_range(2, 6)) send_random_query();
         end else if (r < 94) begin
            repeat ($urandom_range(1, 6)) begin
               noise.kind    = ($urandom_range(0, 1) == 1) ? KIND_QUERY : KIND_VERTEX;
               noise.restart = $urandom_range(0, 1) == 1;
               noise.x_coord = coord_type'($urandom);
               noise.y_coord = coord_type'($urandom);
               send_item(noise);
            end
         end else begin
            // degenerate polygons: one or two vertices, or all on one row
            n  = $urandom_range(1, 5);
            cy = int'(coord_type'($urandom));
            for (int i = 0; i < n; i++)
               send_vertex(i == 0, coord_type'($urandom),
                           (n > 2) ? coord_type'(cy) : coord_type'($urandom));
            repeat ($urandom_range(2, 6)) send_random_query();
         end
         if ($urandom_range(0, 99) < 4) wait_for_verdicts();
      end
   endtask

   task automatic test_drain_pause();
      load_polygon(12, 1500);
      repeat (20) send_random_query();
      wait_for_verdicts();
      repeat (20) send_random_query();
      load_polygon(5, 60);
      repeat (10) send_random_query();
   endtask

   task automatic test_result_backpressure();
      load_polygon(8, 1500);
      hold_token++;
      // keep offering queries so the chain fills and stalls the input
      repeat (3 * MAX_VERTICES) send_random_query();
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : verdict_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual inside_res=%0b truncated=%0b",
                     $time, rsp_data.inside_res, rsp_data.truncated);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            verdicts_checked++;
            if (rsp_data.inside_res !== want.inside_res) begin
               $display("%0t: inside_res mismatch: expected %0b actual %0b",
                        $time, want.inside_res, rsp_data.inside_res);
               error_count++;
            end
            if (rsp_data.truncated !== want.truncated) begin
               $display("%0t: truncated mismatch: expected %0b actual %0b",
                        $time, want.truncated, rsp_data.truncated);
               error_count++;
            end
         end
      end
   end

   // count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 26;
      recv_idle_pct = 65;
      test_directed_cases();
      test_store_overflow();
      test_random_polygons(420);

      send_idle_pct = 65;
      recv_idle_pct = 26;
      test_random_polygons(420);
      test_drain_pause();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_polygons(420);
      test_result_backpressure();

      wait_for_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d vertex and %0d query transfers; %0d verdicts checked.",
               vertices_sent, queries_sent, verdicts_checked);
      $display("Included %0d store overflows, degenerate polygons and long result hold-off.",
               overflow_runs);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> point_in_polygon_test.f
sv/pip_pkg.sv
sv/pip_cell.sv
sv/point_in_polygon_test.sv
tb/tb_point_in_polygon_test.sv
